// ===== hdl/decimal_radix_sorter_core_assert.svh =====
// ----------------------------------------------------------------------------
// Decimal radix sorter assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_RADIX_SORTER_CORE_ASSERT_SVH
`define DECIMAL_RADIX_SORTER_CORE_ASSERT_SVH

// Antecedent implies consequent in the same cycle
`define DRS_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle
`define DRS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hdl/drs_pkg.sv =====
// ----------------------------------------------------------------------------
// Decimal radix sorter package
// Sizes, divide-by-ten constants, digit-count helper and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package drs_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int MAX_DIGITS  = 5;
    localparam int VAL_W       = 16;
    localparam int IDX_W       = $clog2(MAX_ITEMS);
    localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
    localparam int NUM_BKT     = 10;
    localparam int BKT_W       = $clog2(NUM_BKT);
    localparam int DIG_W       = $clog2(MAX_DIGITS + 1);
    localparam int ENT_W       = 2 * VAL_W;

    // x / 10 == (x * 52429) >> 19, exact for every 16-bit x
    localparam int RECIP_W     = 17;
    localparam logic [RECIP_W-1:0] RECIP10 = 17'd52429;
    localparam int RECIP_SHIFT = 19;

    // Number of decimal digits of v, zero for v == 0, capped at MAX_DIGITS
    function automatic logic [DIG_W-1:0] digits_of(input logic [VAL_W-1:0] v);
        int d;
        if (v >= 16'd10000)
            d = 5;
        else if (v >= 16'd1000)
            d = 4;
        else if (v >= 16'd100)
            d = 3;
        else if (v >= 16'd10)
            d = 2;
        else if (v != '0)
            d = 1;
        else
            d = 0;
        if (d > MAX_DIGITS)
            d = MAX_DIGITS;
        return DIG_W'(d);
    endfunction

    // Controller to datapath
    typedef struct packed {
        logic             load;
        logic             load_first;
        logic [IDX_W-1:0] load_addr;
        logic             clear_counts;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             walk;
        logic             scatter_mode;
        logic             prefix_en;
        logic [BKT_W-1:0] prefix_idx;
        logic             swap;
        logic             cap_out;
        logic             out_last;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic             pipe_busy;
        logic [DIG_W-1:0] digits;
    } sts_t;

endpackage

`default_nettype wire

// ===== hdl/drs_datapath.sv =====
// ----------------------------------------------------------------------------
// Decimal radix sorter datapath
// Ping-pong value stores, a two-stage digit extraction pipeline, the bucket
// counters with their prefix adder, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module drs_datapath
    import drs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [VAL_W-1:0] value_in,
    input  cmd_t             cmd,
    output sts_t             sts,
    output logic [VAL_W-1:0] value_out,
    output logic             last_out
);

    // Each entry holds {value, value / 10^place}
    logic [ENT_W-1:0] mem_a [0:MAX_ITEMS-1];
    logic [ENT_W-1:0] mem_b [0:MAX_ITEMS-1];
    logic [ENT_W-1:0] rdata_a_reg;
    logic [ENT_W-1:0] rdata_b_reg;

    logic             sel_reg;
    logic             s1_valid_reg;
    logic             s2_valid_reg;
    logic [VAL_W-1:0] s2_val_reg;
    logic [VAL_W-1:0] s2_q10_reg;
    logic [BKT_W-1:0] s2_dig_reg;
    logic [CNT_W-1:0] cnt_reg [0:NUM_BKT-1];
    logic [CNT_W-1:0] acc_reg;
    logic [VAL_W-1:0] max_reg;
    logic [VAL_W-1:0] out_value_reg;
    logic             out_last_reg;

    logic [ENT_W-1:0]         src_rdata;
    logic [VAL_W-1:0]         src_val;
    logic [VAL_W-1:0]         src_quot;
    logic [VAL_W+RECIP_W-1:0] prod;
    logic [VAL_W-1:0]         q10;
    logic [VAL_W-1:0]         q10x10;
    logic [VAL_W-1:0]         rem;
    logic [CNT_W-1:0]         ptr;
    logic [IDX_W-1:0]         wr_addr;
    logic [ENT_W-1:0]         wr_data;
    logic                     wr_en;

    // Select the source store of the current pass
    assign src_rdata = sel_reg ? rdata_b_reg : rdata_a_reg;
    assign src_val   = src_rdata[ENT_W-1:VAL_W];
    assign src_quot  = src_rdata[VAL_W-1:0];

    // Split quotient into next quotient and current digit
    assign prod   = {{RECIP_W{1'b0}}, src_quot} * {{VAL_W{1'b0}}, RECIP10};
    assign q10    = VAL_W'(prod >> RECIP_SHIFT);
    assign q10x10 = (q10 << 3) + (q10 << 1);
    assign rem    = src_quot - q10x10;

    // Scatter target comes from the running bucket pointer
    assign ptr     = cnt_reg[s2_dig_reg];
    assign wr_addr = ptr[IDX_W-1:0];
    assign wr_data = {s2_val_reg, s2_q10_reg};
    assign wr_en   = s2_valid_reg && cmd.scatter_mode;

    // Store A: load port, scatter target on odd passes
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            mem_a[cmd.load_addr] <= {value_in, value_in};
        else if (wr_en && sel_reg)
            mem_a[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rdata_a_reg <= mem_a[cmd.rd_addr];
    end

    // Store B: scatter target on even passes
    always_ff @(posedge clk)
    begin
        if (wr_en && !sel_reg)
            mem_b[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rdata_b_reg <= mem_b[cmd.rd_addr];
    end

    // Track which store holds the current order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_reg <= 1'b0;
        else if (cmd.load && cmd.load_first)
            sel_reg <= 1'b0;
        else if (cmd.swap)
            sel_reg <= ~sel_reg;
    end

    // Advance pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.walk;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Register digit stage
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_val_reg <= src_val;
            s2_q10_reg <= q10;
            s2_dig_reg <= rem[BKT_W-1:0];
        end
    end

    // Bucket counters: clear, convert to start offsets, bump per beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BKT; b++)
                cnt_reg[b] <= '0;
            acc_reg <= '0;
        end
        else if (cmd.clear_counts)
        begin
            for (int b = 0; b < NUM_BKT; b++)
                cnt_reg[b] <= '0;
            acc_reg <= '0;
        end
        else if (cmd.prefix_en)
        begin
            cnt_reg[cmd.prefix_idx] <= acc_reg;
            acc_reg                 <= acc_reg + cnt_reg[cmd.prefix_idx];
        end
        else if (s2_valid_reg)
        begin
            cnt_reg[s2_dig_reg] <= ptr + CNT_W'(1);
        end
    end

    // Track the largest value of the set
    always_ff @(posedge clk)
    begin
        if (cmd.load && (cmd.load_first || value_in > max_reg))
            max_reg <= value_in;
    end

    // Capture result beat
    always_ff @(posedge clk)
    begin
        if (cmd.cap_out)
        begin
            out_value_reg <= src_val;
            out_last_reg  <= cmd.out_last;
        end
    end

    assign sts.pipe_busy = s1_valid_reg | s2_valid_reg;
    assign sts.digits    = digits_of(max_reg);
    assign value_out     = out_value_reg;
    assign last_out      = out_last_reg;

endmodule

`default_nettype wire

// ===== hdl/drs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Decimal radix sorter controller
// Sequences load, the count / prefix / scatter passes per digit place, and
// the emission of the sorted run.
// ----------------------------------------------------------------------------
`default_nettype none

module drs_ctrl
    import drs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic last_in,
    input  logic out_stall,
    output logic in_stall,
    output logic out_valid,
    output cmd_t cmd,
    input  sts_t sts
);

    typedef enum logic [9:0] {
        S_LOAD      = 10'b00_0000_0001,
        S_CLEAR     = 10'b00_0000_0010,
        S_COUNT     = 10'b00_0000_0100,
        S_DRAIN_C   = 10'b00_0000_1000,
        S_PREFIX    = 10'b00_0001_0000,
        S_SCATTER   = 10'b00_0010_0000,
        S_DRAIN_S   = 10'b00_0100_0000,
        S_EMIT_RD   = 10'b00_1000_0000,
        S_EMIT_CAP  = 10'b01_0000_0000,
        S_EMIT_WAIT = 10'b10_0000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [BKT_W-1:0] bkt_reg, bkt_next;
    logic [DIG_W-1:0] place_reg, place_next;

    logic in_accept;
    logic out_beat;
    logic idx_end;
    logic set_full;

    assign in_stall  = (state_reg != S_LOAD);
    assign out_valid = (state_reg == S_EMIT_WAIT);
    assign in_accept = in_valid && !in_stall;
    assign out_beat  = out_valid && !out_stall;
    assign idx_end   = (idx_reg == IDX_W'(n_reg - CNT_W'(1)));
    assign set_full  = (count_reg == CNT_W'(MAX_ITEMS - 1));

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        bkt_next   = bkt_reg;
        place_next = place_reg;
        cmd        = '0;

        case (state_reg)
            S_LOAD:
            begin
                cmd.load       = in_accept;
                cmd.load_first = (count_reg == '0);
                cmd.load_addr  = count_reg[IDX_W-1:0];
                if (in_accept)
                begin
                    count_next = count_reg + CNT_W'(1);
                    if (last_in || set_full)
                    begin
                        n_next     = count_reg + CNT_W'(1);
                        place_next = '0;
                        state_next = S_CLEAR;
                    end
                end
            end
            S_CLEAR:
            begin
                cmd.clear_counts = 1'b1;
                idx_next         = '0;
                if (place_reg < sts.digits)
                    state_next = S_COUNT;
                else
                    state_next = S_EMIT_RD;
            end
            S_COUNT:
            begin
                cmd.walk    = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = idx_reg;
                idx_next    = idx_reg + IDX_W'(1);
                if (idx_end)
                    state_next = S_DRAIN_C;
            end
            S_DRAIN_C:
            begin
                if (!sts.pipe_busy)
                begin
                    bkt_next   = '0;
                    state_next = S_PREFIX;
                end
            end
            S_PREFIX:
            begin
                cmd.prefix_en  = 1'b1;
                cmd.prefix_idx = bkt_reg;
                bkt_next       = bkt_reg + BKT_W'(1);
                if (bkt_reg == BKT_W'(NUM_BKT - 1))
                begin
                    idx_next   = '0;
                    state_next = S_SCATTER;
                end
            end
            S_SCATTER:
            begin
                cmd.walk         = 1'b1;
                cmd.rd_en        = 1'b1;
                cmd.rd_addr      = idx_reg;
                cmd.scatter_mode = 1'b1;
                idx_next         = idx_reg + IDX_W'(1);
                if (idx_end)
                    state_next = S_DRAIN_S;
            end
            S_DRAIN_S:
            begin
                cmd.scatter_mode = 1'b1;
                if (!sts.pipe_busy)
                begin
                    cmd.swap   = 1'b1;
                    place_next = place_reg + DIG_W'(1);
                    state_next = S_CLEAR;
                end
            end
            S_EMIT_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = idx_reg;
                state_next  = S_EMIT_CAP;
            end
            S_EMIT_CAP:
            begin
                cmd.cap_out  = 1'b1;
                cmd.out_last = idx_end;
                state_next   = S_EMIT_WAIT;
            end
            S_EMIT_WAIT:
            begin
                if (out_beat)
                begin
                    if (idx_end)
                    begin
                        count_next = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            n_reg     <= '0;
            idx_reg   <= '0;
            bkt_reg   <= '0;
            place_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            n_reg     <= n_next;
            idx_reg   <= idx_next;
            bkt_reg   <= bkt_next;
            place_reg <= place_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/decimal_radix_sorter_core.sv =====
// ----------------------------------------------------------------------------
// Decimal radix sorter core
// Collects up to 64 unsigned 16-bit values, sorts them ascending with one
// stable counting pass per decimal digit (LSD first) and emits the run.
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------
//   in      | in_valid / in_stall   | value_in, last_in
//   out     | out_valid / out_stall | value_out, last_out
//
// Loading takes beats back to back; a set ends on last_in or on its 64th value.
// Each digit pass runs clear, count walk, 10-step prefix and scatter walk,
// each walk followed by a drain of the read/digit pipeline; one more clear
// precedes emission. The pass count is the digit count of the largest value,
// at most 5.
// Emission runs store read, capture and beat for each value, plus stalls; the next value is read after the beat.
// No input beat is taken from the end of a set until its last result leaves.
// Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_radix_sorter_core
    import drs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [VAL_W-1:0] value_in,
    input  logic             last_in,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [VAL_W-1:0] value_out,
    output logic             last_out
);

    cmd_t cmd;
    sts_t sts;

    drs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_in   (last_in),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd),
        .sts       (sts)
    );

    drs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value_in  (value_in),
        .cmd       (cmd),
        .sts       (sts),
        .value_out (value_out),
        .last_out  (last_out)
    );

endmodule

`default_nettype wire

// ===== hdl/drs_checker.sv =====
// ----------------------------------------------------------------------------
// Decimal radix sorter port checker
// Watches the top-level ports for ordering between loading and emission.
// ----------------------------------------------------------------------------
`default_nettype none

`include "decimal_radix_sorter_core_assert.svh"

module drs_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        last_in,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] value_out,
    input  logic        last_out
);

    // A stalled result beat holds
    `DRS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(value_out) && $stable(last_out), "stalled result beat changed")

    // No input beat while results are being shown
    `DRS_ASSERT_SAME(a_no_load_while_emit, out_valid, in_stall, "input open during emission")

    // Input closes once a set is complete
    `DRS_ASSERT_NEXT(a_close_after_last, in_valid && !in_stall && last_in, in_stall, "input open after last beat")

    // Run ends after its last beat
    `DRS_ASSERT_NEXT(a_run_ends, out_valid && !out_stall && last_out, !out_valid, "result shown after last beat")

    // Loading never shows a result in the next cycle
    `DRS_ASSERT_NEXT(a_no_early_result, in_valid && !in_stall, !out_valid, "result right after input beat")

endmodule

bind decimal_radix_sorter_core drs_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last_in   (last_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value_out (value_out),
    .last_out  (last_out)
);

`default_nettype wire

// ===== test/decimal_radix_sorter_core_tb.sv =====
// ----------------------------------------------------------------------------
// Decimal radix sorter core testbench
// Feeds value sets to the sorter and checks every sorted run against a
// digit-by-digit counting sort kept in a scoreboard. A directed part covers
// the extreme values, an all-zero set, a single value and duplicates. A random
// part follows with sets of many lengths, including full sets of 64 values
// with and without the last flag on the final beat. Both channels idle at
// random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module decimal_radix_sorter_core_tb;

    import drs_pkg::*;

    localparam int HOLD_CYCLES    = 500;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_BEATS   = 400;
    localparam int TAIL_CYCLES    = 100;
    localparam int N_DIRECTED     = 21;

    localparam int unsigned DECADE [5] = '{1, 10, 100, 1000, 10000};

    // Directed beats as {last, value}
    localparam logic [VAL_W:0] DIRECTED [N_DIRECTED] = '{
        {1'b0, 16'd65535}, {1'b0, 16'd0}, {1'b0, 16'd9}, {1'b1, 16'd10},
        {1'b0, 16'd0}, {1'b0, 16'd0}, {1'b1, 16'd0},
        {1'b1, 16'd7},
        {1'b0, 16'd500}, {1'b0, 16'd5}, {1'b0, 16'd500}, {1'b0, 16'd50},
        {1'b1, 16'd5},
        {1'b0, 16'd65535}, {1'b0, 16'd1}, {1'b0, 16'd10000}, {1'b0, 16'd9999},
        {1'b0, 16'd1000}, {1'b0, 16'd999}, {1'b0, 16'd100}, {1'b1, 16'd99}
    };

    // Collects each set, sorts it by decimal digits and holds the runs due
    class run_scoreboard;
        logic [VAL_W-1:0] open_set_q[$];
        logic [VAL_W-1:0] sorted_value_q[$];
        logic             sorted_last_q[$];
        int               errors;

        function void note_value(logic [VAL_W-1:0] v, logic l);
            logic [VAL_W-1:0] next_q[$];
            logic [VAL_W-1:0] top;
            int unsigned      div;
            int               places;
            int               p;
            int               b;
            open_set_q = {open_set_q, v};
            if (!l && open_set_q.size() < MAX_ITEMS)
                return;
            // count the digits of the largest value
            top = '0;
            foreach (open_set_q[i])
                if (open_set_q[i] > top)
                    top = open_set_q[i];
            places = 0;
            while (top != 0)
            begin
                top = top / 16'd10;
                places++;
            end
            if (places > MAX_DIGITS)
                places = MAX_DIGITS;
            // run one stable bucket pass per digit place, lowest first
            div = 1;
            for (p = 0; p < places; p++)
            begin
                next_q.delete();
                for (b = 0; b < NUM_BKT; b++)
                    foreach (open_set_q[i])
                        if ((open_set_q[i] / div) % 10 == b)
                            next_q = {next_q, open_set_q[i]};
                open_set_q = next_q;
                div = div * 10;
            end
            foreach (open_set_q[i])
            begin
                sorted_value_q = {sorted_value_q, open_set_q[i]};
                sorted_last_q  = {sorted_last_q, (i == open_set_q.size() - 1)};
            end
            open_set_q.delete();
        endfunction

        function void check_sorted(logic [VAL_W-1:0] v, logic l);
            logic [VAL_W-1:0] ev;
            logic             el;
            if (sorted_value_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result value_out=%0d last_out=%0b",
                             $realtime, v, l);
                return;
            end
            ev = sorted_value_q.pop_front();
            el = sorted_last_q.pop_front();
            if (v !== ev || l !== el)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch value_out exp %0d got %0d, last_out exp %0b got %0b",
                             $realtime, ev, v, el, l);
            end
        endfunction

        function int pending();
            return sorted_value_q.size();
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [VAL_W-1:0] value_in;
    logic             last_in;
    logic             out_valid;
    logic             out_stall;
    logic [VAL_W-1:0] value_out;
    logic             last_out;

    run_scoreboard board;
    bit            calm;
    logic          hold_req;
    int            hold_cnt;
    int            quiet_cycles;

    decimal_radix_sorter_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value_in  (value_in),
        .last_in   (last_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value_out (value_out),
        .last_out  (last_out)
    );

    always #10 clk = ~clk;

    // Offer one beat after a random idle gap, hold it until taken
    task automatic send_beat(input logic [VAL_W-1:0] v, input logic l);
        while (!calm && $urandom_range(0, 99) < 21)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value_in <= v;
        last_in  <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_value(v, l);
    endtask

    // Drive the output stall: one long hold-off on request, else random
    always @(posedge clk)
    begin : rx_stall_gen
        if (hold_cnt != 0)
        begin
            out_stall <= 1'b1;
            hold_cnt  <= hold_cnt - 1;
        end
        else if (hold_req)
        begin
            out_stall <= 1'b1;
            hold_cnt  <= HOLD_CYCLES;
            hold_req  <= 1'b0;
        end
        else
        begin
            out_stall <= !calm && ($urandom_range(0, 99) < 21);
        end
    end

    // Check accepted results and watch for a stuck handshake
    always @(posedge clk)
    begin : result_mon
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_sorted(value_out, last_out);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int               k;
        int               set_len;
        int               span;
        int               sel;
        int               rand_beats;
        int unsigned      lo;
        int unsigned      hi;
        bit               full_set;
        logic             close_full;
        logic             l;
        logic [VAL_W-1:0] v;
        logic [VAL_W-1:0] prev;

        board        = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        value_in     = '0;
        last_in      = 1'b0;
        out_stall    = 1'b0;
        hold_req     = 1'b0;
        hold_cnt     = 0;
        quiet_cycles = 0;
        calm         = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sets: extremes, all zero, single value, duplicates
        for (k = 0; k < N_DIRECTED; k++)
            send_beat(DIRECTED[k][VAL_W-1:0], DIRECTED[k][VAL_W]);

        // Pause the sender until every directed run has drained
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);

        // Ask for one long receiver hold-off while the sender keeps going
        hold_req <= 1'b1;

        // Random sets, mostly short, sometimes full
        rand_beats = 0;
        prev       = '0;
        while (rand_beats < RANDOM_BEATS)
        begin
            calm       = (rand_beats >= 150 && rand_beats < 260);
            full_set   = ($urandom_range(0, 9) == 0);
            set_len    = full_set ? MAX_ITEMS : $urandom_range(1, 12);
            close_full = 1'($urandom_range(0, 1));
            span       = $urandom_range(0, 5);
            for (k = 0; k < set_len; k++)
            begin
                if (k != 0 && $urandom_range(0, 7) == 0)
                    v = prev;
                else if ($urandom_range(0, 9) == 0)
                    v = VAL_W'($urandom_range(0, 65535));
                else
                begin
                    sel = $urandom_range(0, span);
                    lo  = (sel == 0) ? 0 : DECADE[sel-1];
                    hi  = (sel == 5) ? 65535 : DECADE[sel] - 1;
                    v   = VAL_W'($urandom_range(lo, hi));
                end
                if (k == set_len - 1)
                    l = full_set ? close_full : 1'b1;
                else
                    l = 1'b0;
                send_beat(v, l);
                prev = v;
                rand_beats++;
            end
        end
        calm     = 1'b0;
        in_valid <= 1'b0;

        // Drain, then allow time for any stray result
        while (board.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (board.errors == 0 && board.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/drs_pkg.sv
hdl/drs_datapath.sv
hdl/drs_ctrl.sv
hdl/decimal_radix_sorter_core.sv
hdl/drs_checker.sv
test/decimal_radix_sorter_core_tb.sv
